@@ rtl/core/modular_inverse_euclid_assert.svh @@
// Assertion macros for the modular inverse block, clocked on clk and disabled in reset.
`ifndef MODULAR_INVERSE_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EUCLID_ASSERT_SVH
`ifndef SYNTHESIS
`define MIE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define MIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MIE_ASSERT(lbl, prop, msg)
`define MIE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/mie_pkg.sv @@
// Shared types and constants of the modular inverse block.
package mie_pkg;
	localparam int WORD_BITS = 32;
	localparam int CNT_BITS  = $clog2(WORD_BITS);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	localparam word_t WORD_ONE = word_t'(1);
	localparam word_t WORD_TWO = word_t'(2);
	localparam cnt_t  CNT_LAST = cnt_t'(WORD_BITS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TEST,
		S_DIV,
		S_COMMIT,
		S_RED,
		S_NEG,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic commit;
		logic mark_ok;
		logic reduce;
		logic negate;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic small_mod;
		logic rc_zero;
		logic rp_one;
		logic out_free;
	} status_t;
endpackage

@@ rtl/core/mie_req_if.sv @@
// Request channel: number and modulus to invert.
interface mie_req_if;
	import mie_pkg::*;
	logic  valid;
	logic  ready;
	word_t value;
	word_t modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink (input valid, input value, input modulus, output ready);
endinterface

@@ rtl/core/mie_rsp_if.sv @@
// Response channel: inverse and found flag.
interface mie_rsp_if;
	import mie_pkg::*;
	logic  valid;
	logic  ready;
	word_t inverse;
	logic  found;

	modport source (output valid, output inverse, output found, input ready);
	modport sink (input valid, input inverse, input found, output ready);
endinterface

@@ rtl/core/mie_ctrl.sv @@
// Sequencer of the Euclid rounds, the bit-serial division and the final reduction.
module mie_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  mie_pkg::status_t status,
	output mie_pkg::cmd_t   cmd
);
	import mie_pkg::*;

	state_t state_q, state_d;
	cnt_t   cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_TEST;
				end
			end
			S_TEST: begin
				if (status.small_mod) begin
					state_d = S_DONE;
				end else if (status.rc_zero) begin
					// gcd sits in the previous remainder
					if (status.rp_one) begin
						cmd.mark_ok = 1'b1;
						state_d     = S_RED;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					cmd.div_start = 1'b1;
					cnt_d         = '0;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + cnt_t'(1);
				if (cnt_q == CNT_LAST) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_TEST;
			end
			S_RED: begin
				cmd.reduce = 1'b1;
				state_d    = S_NEG;
			end
			S_NEG: begin
				cmd.negate = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`include "modular_inverse_euclid_assert.svh"

	`MIE_ASSERT(a_one_cmd, $onehot0(cmd), "more than one datapath command")
	`MIE_ASSERT_NEXT(a_div_len, state_q == S_DIV && cnt_q != CNT_LAST, state_q == S_DIV, "division cut short")
	`MIE_ASSERT(a_ready_idle, req_ready == (state_q == S_IDLE), "ready outside idle")
endmodule

@@ rtl/core/mie_dp.sv @@
// Datapath: remainders, coefficient magnitudes, restoring divider and result register.
module mie_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  mie_pkg::word_t  value,
	input  mie_pkg::word_t  modulus,
	input  mie_pkg::cmd_t   cmd,
	output mie_pkg::status_t status,
	output logic            out_valid,
	input  logic            out_ready,
	output mie_pkg::word_t  out_inverse,
	output logic            out_found
);
	import mie_pkg::*;

	word_t rp_q, rc_q, sp_q, sc_q, m_q;
	word_t rem_q, dvd_q, acc_q;
	logic  neg_q, ok_q;
	word_t out_inv_q;
	logic  out_found_q, out_valid_q;

	logic [WORD_BITS:0] rem_sh;
	logic [WORD_BITS:0] rem_diff;
	logic               qbit;
	word_t              rem_next;
	word_t              acc_next;
	word_t              sp_red;

	// one quotient bit per step; acc builds quotient times sc from the top bit down
	always_comb begin
		rem_sh   = {rem_q, dvd_q[WORD_BITS-1]};
		rem_diff = rem_sh - {1'b0, rc_q};
		qbit     = (rem_sh >= {1'b0, rc_q});
		rem_next = qbit ? rem_diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
		acc_next = {acc_q[WORD_BITS-2:0], 1'b0} + (qbit ? sc_q : '0);
		sp_red   = (sp_q >= m_q) ? (sp_q - m_q) : sp_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rp_q  <= value;
			rc_q  <= modulus;
			m_q   <= modulus;
			sp_q  <= WORD_ONE;
			sc_q  <= '0;
			neg_q <= 1'b0;
			ok_q  <= 1'b0;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			dvd_q <= rp_q;
			acc_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[WORD_BITS-2:0], 1'b0};
			acc_q <= acc_next;
		end
		if (cmd.commit) begin
			rp_q  <= rc_q;
			rc_q  <= rem_q;
			sp_q  <= sc_q;
			sc_q  <= sp_q + acc_q;
			neg_q <= ~neg_q;
		end
		if (cmd.mark_ok) begin
			ok_q <= 1'b1;
		end
		if (cmd.reduce) begin
			sp_q <= sp_red;
		end
		if (cmd.negate && neg_q && sp_q != '0) begin
			sp_q <= m_q - sp_q;
		end
		if (cmd.emit) begin
			out_inv_q   <= ok_q ? sp_q : WORD_ONE;
			out_found_q <= ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.small_mod = (m_q < WORD_TWO);
	assign status.rc_zero   = (rc_q == '0);
	assign status.rp_one    = (rp_q == WORD_ONE);
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_inverse = out_inv_q;
	assign out_found   = out_found_q;

	`include "modular_inverse_euclid_assert.svh"

	`MIE_ASSERT_NEXT(a_rem_below, cmd.div_step, rem_q < rc_q, "remainder not below divisor")
	`MIE_ASSERT_NEXT(a_sign_flip, cmd.commit, neg_q != $past(neg_q), "sign did not alternate")
	`MIE_ASSERT(a_emit_free, !cmd.emit || !out_valid_q || out_ready, "result overwritten")
	`MIE_ASSERT_NEXT(a_found_range, cmd.emit && ok_q, out_found_q && out_inv_q < m_q,
		"inverse out of range")
endmodule

@@ rtl/core/modular_inverse_euclid.sv @@
// Modular inverse by the extended Euclidean algorithm: one request at a time, one
// response per request. Each Euclid round runs a restoring divider one quotient bit
// per cycle and folds the quotient into the Bezout coefficient as it goes; a request
// of 32-bit operands takes at most about 46 rounds. A modulus below 2 or a gcd other
// than 1 answers inverse 1 with found low. A new request is taken as soon as the
// previous result sits in the output register.
module modular_inverse_euclid (
	input logic       clk,
	input logic       arst_n,
	mie_req_if.sink   req,
	mie_rsp_if.source rsp
);
	import mie_pkg::*;

	cmd_t    cmd;
	status_t status;

	mie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mie_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (req.value),
		.modulus     (req.modulus),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_inverse (rsp.inverse),
		.out_found   (rsp.found)
	);
endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the modular inverse block: directed and random requests.
module tb_top;
	import mie_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RANDOM_REQS  = 350;
	localparam int SETTLE_CYCLES = 1700;
	localparam int IDLE_LIMIT   = 12000;
	localparam int HOLD_CYCLES  = 4000;
	localparam int HOLD_AFTER   = 15;

	typedef struct {
		word_t value;
		word_t modulus;
	} operands_t;

	typedef struct {
		word_t value;
		word_t modulus;
		word_t inverse;
		logic  found;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;

	mie_req_if req_ch ();
	mie_rsp_if rsp_ch ();

	modular_inverse_euclid dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	operands_t pending_operands[$];
	answer_t   owed_answers[$];

	int send_gap;
	int recv_gap;
	int hold_left;
	logic hold_done;
	int requests_sent;
	int answers_seen;
	int found_seen;
	int fail_count = 0;
	int idle_cycles;

	always #(HALF_PERIOD) clk = ~clk;

	// Extended Euclid on the value's Bezout coefficient, tracked as magnitude plus sign.
	function automatic answer_t modular_inverse(word_t value, word_t modulus);
		logic [63:0] r_prev, r_cur, r_next, s_prev, s_cur, s_next, quot;
		logic s_neg;
		answer_t ans;
		ans.value   = value;
		ans.modulus = modulus;
		ans.inverse = WORD_ONE;
		ans.found   = 1'b0;
		if (modulus < WORD_TWO)
			return ans;
		r_prev = 64'(value);
		r_cur  = 64'(modulus);
		s_prev = 64'd1;
		s_cur  = 64'd0;
		s_neg  = 1'b0;
		while (r_cur != 64'd0) begin
			quot   = r_prev / r_cur;
			r_next = r_prev - quot * r_cur;
			s_next = s_prev + quot * s_cur;
			r_prev = r_cur;
			r_cur  = r_next;
			s_prev = s_cur;
			s_cur  = s_next;
			s_neg  = !s_neg;
		end
		if (r_prev != 64'd1)
			return ans;
		r_next = s_prev % 64'(modulus);
		if (s_neg && r_next != 64'd0)
			r_next = 64'(modulus) - r_next;
		ans.inverse = word_t'(r_next);
		ans.found   = 1'b1;
		return ans;
	endfunction

	// Mostly back to back, sometimes a short pause, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	function automatic operands_t random_operands();
		operands_t op;
		int kind;
		int unsigned factor;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			op.value   = $urandom;
			op.modulus = $urandom;
		end else if (kind < 60) begin
			op.value   = $urandom;
			op.modulus = $urandom_range(2, 1000);
		end else if (kind < 75) begin
			// shared factor: no inverse
			factor     = $urandom_range(2, 1000);
			op.value   = factor * $urandom_range(0, 4000000);
			op.modulus = factor * $urandom_range(1, 4000000);
		end else if (kind < 90) begin
			op.value   = $urandom | 32'h8000_0000;
			op.modulus = $urandom | 32'h8000_0001;
		end else begin
			op.value   = ($urandom_range(0, 1) != 0) ? word_t'($urandom_range(0, 1)) : $urandom;
			op.modulus = $urandom_range(0, 3);
		end
		return op;
	endfunction

	task automatic queue_request(word_t value, word_t modulus);
		operands_t op;
		op.value   = value;
		op.modulus = modulus;
		pending_operands.push_back(op);
	endtask

	// Request side: hold valid until taken, then pause or offer the next one.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic offering;
		operands_t op;
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.value   <= '0;
			req_ch.modulus <= '0;
			send_gap       <= 0;
			requests_sent  <= 0;
		end else begin
			offering = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				owed_answers.push_back(modular_inverse(req_ch.value, req_ch.modulus));
				requests_sent <= requests_sent + 1;
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap     <= send_gap - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_operands.size() > 0) begin
					op = pending_operands.pop_front();
					req_ch.valid   <= 1'b1;
					req_ch.value   <= op.value;
					req_ch.modulus <= op.modulus;
					send_gap       <= pick_gap();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response side: check each answer against the oldest owed one.
	always @(posedge clk or negedge arst_n) begin : collect_answers
		answer_t want;
		int gap_next;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_gap     <= 0;
			answers_seen <= 0;
			found_seen   <= 0;
		end else begin
			gap_next = (recv_gap > 0) ? recv_gap - 1 : 0;
			if (rsp_ch.valid && rsp_ch.ready) begin
				answers_seen <= answers_seen + 1;
				gap_next = pick_gap();
				if (owed_answers.size() == 0) begin
					$error("unexpected response: inverse %h found %b", rsp_ch.inverse,
						rsp_ch.found);
					fail_count++;
				end else begin
					want = owed_answers.pop_front();
					if (want.found)
						found_seen <= found_seen + 1;
					if (rsp_ch.inverse !== want.inverse) begin
						$error("inverse: expected %h, got %h (value %h modulus %h)",
							want.inverse, rsp_ch.inverse, want.value, want.modulus);
						fail_count++;
					end
					if (rsp_ch.found !== want.found) begin
						$error("found: expected %b, got %b (value %h modulus %h)",
							want.found, rsp_ch.found, want.value, want.modulus);
						fail_count++;
					end
				end
			end
			recv_gap     <= gap_next;
			rsp_ch.ready <= (gap_next == 0) && (hold_left == 0);
		end
	end

	// Hold off the response side once for a long stretch so the input backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && answers_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("[modular_inverse_euclid] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;

		// small moduli
		queue_request(32'd5, 32'd0);
		queue_request(32'd5, 32'd1);
		queue_request(32'd0, 32'd0);
		queue_request(32'hFFFF_FFFF, 32'd1);
		// zero value and shared factors
		queue_request(32'd0, 32'd7);
		queue_request(32'd0, 32'hFFFF_FFFF);
		queue_request(32'd12, 32'd18);
		queue_request(32'd97, 32'd97);
		queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(32'd2, 32'h8000_0000);
		// plain inverses, some with the value at or above the modulus
		queue_request(32'd1, 32'd2);
		queue_request(32'd3, 32'd2);
		queue_request(32'd3, 32'd7);
		queue_request(32'd1234567, 32'd4294967291);
		queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		queue_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		queue_request(32'h8000_0000, 32'hFFFF_FFFF);
		queue_request(32'hFFFF_FFFF, 32'h8000_0000);
		queue_request(32'd100, 32'd3);
		// consecutive Fibonacci numbers: the longest Euclid chain
		queue_request(32'd1836311903, 32'd2971215073);
		queue_request(32'd2971215073, 32'd1836311903);
		repeat (RANDOM_REQS)
			pending_operands.push_back(random_operands());

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_operands.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (owed_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d with an inverse, %0d without",
			requests_sent, found_seen, answers_seen - found_seen);
		$display("response side held off once for %0d cycles", HOLD_CYCLES);
		if (fail_count == 0 && owed_answers.size() == 0)
			$display("[modular_inverse_euclid] OK");
		else
			$display("[modular_inverse_euclid] ERROR");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mie_pkg.sv
rtl/core/mie_req_if.sv
rtl/core/mie_rsp_if.sv
rtl/core/mie_ctrl.sv
rtl/core/mie_dp.sv
rtl/core/modular_inverse_euclid.sv
bench/tb_top.sv
